// ===== rtl/core/wfw_pkg.sv =====
// Shared constants, types and helpers of the windowed frame buffer writer.
package wfw_pkg;

    localparam int PANEL_WIDTH  = 320;
    localparam int PANEL_HEIGHT = 240;
    localparam int STORE_SIZE   = PANEL_WIDTH * PANEL_HEIGHT;
    localparam int ADDR_W       = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
    localparam int CNT_W        = $clog2(STORE_SIZE + 1);
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [QPTR_W-1:0] t_qptr;
    typedef logic [QCNT_W-1:0] t_qcnt;

    typedef enum logic [2:0] {
        KIND_SET_WINDOW  = 3'd0,
        KIND_WRITE_PIXEL = 3'd1,
        KIND_REPEAT      = 3'd2,
        KIND_FILL_RECT   = 3'd3,
        KIND_MARK_ALL    = 3'd4,
        KIND_CLEAR_DIRTY = 3'd5,
        KIND_READ_PIXEL  = 3'd6,
        KIND_CLEAR_ALL   = 3'd7
    } t_kind;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_WINDOW,
        OP_RUN,
        OP_FILL,
        OP_MARK,
        OP_UNMARK,
        OP_READ,
        OP_CLEAR
    } t_op;

    typedef enum logic [2:0] {
        BK_SWEEP,
        BK_IDLE,
        BK_RUN,
        BK_FILL,
        BK_READ
    } t_bk_state;

    typedef struct packed {
        t_kind        kind;
        logic [9:0]   coord_x;
        logic [9:0]   coord_y;
        logic [10:0]  extent_x;
        logic [10:0]  extent_y;
        logic [15:0]  pixel_value;
        logic [16:0]  repeat_count;
    } t_in_item;

    typedef struct packed {
        logic         dirty_valid;
        logic [9:0]   dirty_first;
        logic [9:0]   dirty_last;
        logic [16:0]  cursor_pos;
        logic [15:0]  read_data;
    } t_result;

    // Classified command handed from the front end to the back end.
    typedef struct packed {
        t_op          op;
        t_addr        addr;
        logic [9:0]   row;
        logic [10:0]  width;
        logic [10:0]  height;
        t_cnt         pixels;
        logic [16:0]  count;
        logic [15:0]  pixel;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

    typedef struct packed {
        logic        flag;
        logic [9:0]  lo;
        logic [9:0]  hi;
    } t_dirty;

    function automatic logic [9:0] clamp_col(input logic [10:0] v);
        logic [9:0] c;
        if (32'(v) >= PANEL_WIDTH) begin
            c = 10'(PANEL_WIDTH - 1);
        end else begin
            c = v[9:0];
        end
        return c;
    endfunction

    function automatic logic [9:0] clamp_row(input logic [10:0] v);
        logic [9:0] c;
        if (32'(v) >= PANEL_HEIGHT) begin
            c = 10'(PANEL_HEIGHT - 1);
        end else begin
            c = v[9:0];
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/windowed_framebuffer_writer.sv =====
// Top level of the windowed frame buffer writer: front end, command queue and back end.
//
// Usage: drive a transaction on i_item and raise start; it is taken at a clock edge
// where start is high and busy is low. Every transaction yields exactly one result on
// o_result, marked by o_valid for one cycle, in the order the transactions came in.
// The back end takes each command from the queue in its idle state, where set window,
// mark/clear dirty, an ignored fill and clear all finish; a read finishes in the read
// state after the registered store read, a run of N pixels (a single pixel write is a
// run of one) or a clipped W x H fill with its last pixel write. It spends one cycle
// per pixel written through the single store write port, and single pixel writes are
// not back to back: each passes the idle state. A two-entry queue lets new transactions
// be taken while the back end is still writing; busy rises when it is full. After
// reset, and after a clear all transaction, the frame store is zeroed one pixel per
// cycle, all PANEL_WIDTH * PANEL_HEIGHT pixels (76800 at 320 x 240); busy stays high
// until that pass ends. The result of a clear all leaves before that pass ends.
// The receiver cannot stall; each result must be taken in its strobe cycle.
module windowed_framebuffer_writer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  wfw_pkg::t_in_item i_item,
    output logic              busy,
    output logic              o_valid,
    output wfw_pkg::t_result  o_result
);

    wfw_pkg::t_cmd    front_cmd;
    wfw_pkg::t_q_head q_head;
    logic             q_full;
    logic             q_pop;
    logic             push;
    logic             clearing;

    assign busy = q_full || clearing;
    assign push = start && !busy;

    wfw_front u_front (
        .i_item (i_item),
        .o_cmd  (front_cmd)
    );

    wfw_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (front_cmd),
        .i_pop      (q_pop),
        .o_head     (q_head),
        .o_full     (q_full)
    );

    wfw_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (q_head),
        .o_pop      (q_pop),
        .o_clearing (clearing),
        .o_valid    (o_valid),
        .o_result   (o_result)
    );

endmodule

// ===== rtl/core/wfw_front.sv =====
// Front end: clamps and clips the incoming transaction and classifies it into a command.
module wfw_front (
    input  wfw_pkg::t_in_item i_item,
    output wfw_pkg::t_cmd     o_cmd
);

    logic [9:0]  win_x0, win_x1, win_y0, win_y1, win_x1_raw, win_y1_raw;
    logic [9:0]  rd_x, rd_y;
    logic [10:0] win_w, win_h, fill_w, fill_h;
    logic        fill_ok;

    assign win_x0     = wfw_pkg::clamp_col({1'b0, i_item.coord_x});
    assign win_y0     = wfw_pkg::clamp_row({1'b0, i_item.coord_y});
    assign win_x1_raw = wfw_pkg::clamp_col(i_item.extent_x);
    assign win_y1_raw = wfw_pkg::clamp_row(i_item.extent_y);
    assign win_x1     = (win_x1_raw < win_x0) ? win_x0 : win_x1_raw;
    assign win_y1     = (win_y1_raw < win_y0) ? win_y0 : win_y1_raw;
    assign win_w      = {1'b0, win_x1} - {1'b0, win_x0} + 11'd1;
    assign win_h      = {1'b0, win_y1} - {1'b0, win_y0} + 11'd1;

    assign rd_x = win_x0;
    assign rd_y = win_y0;

    // A fill that starts off the panel or is empty does nothing; otherwise it is
    // clipped at the right and bottom edges.
    assign fill_ok = (32'(i_item.coord_x) < wfw_pkg::PANEL_WIDTH)
                  && (32'(i_item.coord_y) < wfw_pkg::PANEL_HEIGHT)
                  && (i_item.extent_x != 11'd0) && (i_item.extent_y != 11'd0);
    assign fill_w = (32'(i_item.coord_x) + 32'(i_item.extent_x) > wfw_pkg::PANEL_WIDTH)
                  ? 11'(wfw_pkg::PANEL_WIDTH - 32'(i_item.coord_x)) : i_item.extent_x;
    assign fill_h = (32'(i_item.coord_y) + 32'(i_item.extent_y) > wfw_pkg::PANEL_HEIGHT)
                  ? 11'(wfw_pkg::PANEL_HEIGHT - 32'(i_item.coord_y)) : i_item.extent_y;

    always_comb begin
        o_cmd       = '0;
        o_cmd.op    = wfw_pkg::OP_NOP;
        o_cmd.pixel = i_item.pixel_value;
        unique case (i_item.kind)
            wfw_pkg::KIND_SET_WINDOW: begin
                o_cmd.op     = wfw_pkg::OP_WINDOW;
                o_cmd.addr   = wfw_pkg::t_addr'(win_y0 * wfw_pkg::PANEL_WIDTH + win_x0);
                o_cmd.row    = win_y0;
                o_cmd.width  = win_w;
                o_cmd.height = win_h;
                o_cmd.pixels = wfw_pkg::t_cnt'(win_w) * wfw_pkg::t_cnt'(win_h);
            end
            wfw_pkg::KIND_WRITE_PIXEL: begin
                o_cmd.op    = wfw_pkg::OP_RUN;
                o_cmd.count = 17'd1;
            end
            wfw_pkg::KIND_REPEAT: begin
                o_cmd.op    = wfw_pkg::OP_RUN;
                o_cmd.count = i_item.repeat_count;
            end
            wfw_pkg::KIND_FILL_RECT: begin
                if (fill_ok) begin
                    o_cmd.op = wfw_pkg::OP_FILL;
                end
                o_cmd.addr   = wfw_pkg::t_addr'(i_item.coord_y * wfw_pkg::PANEL_WIDTH
                                                + i_item.coord_x);
                o_cmd.row    = i_item.coord_y;
                o_cmd.width  = fill_w;
                o_cmd.height = fill_h;
            end
            wfw_pkg::KIND_MARK_ALL: begin
                o_cmd.op = wfw_pkg::OP_MARK;
            end
            wfw_pkg::KIND_CLEAR_DIRTY: begin
                o_cmd.op = wfw_pkg::OP_UNMARK;
            end
            wfw_pkg::KIND_READ_PIXEL: begin
                o_cmd.op   = wfw_pkg::OP_READ;
                o_cmd.addr = wfw_pkg::t_addr'(rd_y * wfw_pkg::PANEL_WIDTH + rd_x);
            end
            wfw_pkg::KIND_CLEAR_ALL: begin
                o_cmd.op = wfw_pkg::OP_CLEAR;
            end
        endcase
    end

endmodule

// ===== rtl/core/wfw_queue.sv =====
// Short command queue between the front end and the back end.
module wfw_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  wfw_pkg::t_cmd     i_push_cmd,
    input  logic              i_pop,
    output wfw_pkg::t_q_head  o_head,
    output logic              o_full
);

    wfw_pkg::t_cmd  r_slot [wfw_pkg::QUEUE_DEPTH];
    wfw_pkg::t_qptr r_wr_ptr, n_wr_ptr;
    wfw_pkg::t_qptr r_rd_ptr, n_rd_ptr;
    wfw_pkg::t_qcnt r_count, n_count;

    function automatic wfw_pkg::t_qptr next_ptr(input wfw_pkg::t_qptr p);
        wfw_pkg::t_qptr q;
        if (p == wfw_pkg::t_qptr'(wfw_pkg::QUEUE_DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + wfw_pkg::t_qptr'(1);
        end
        return q;
    endfunction

    assign o_full       = (r_count == wfw_pkg::t_qcnt'(wfw_pkg::QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? next_ptr(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop ? next_ptr(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + wfw_pkg::t_qcnt'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - wfw_pkg::t_qcnt'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_cmd;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head.valid)
        else $error("queue popped while empty");

    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + wfw_pkg::t_qcnt'(1)))
        else $error("queue fill count lost a push");
`endif

endmodule

// ===== rtl/core/wfw_back.sv =====
// Back end: owns the frame store, window, cursor and dirty range and executes commands.
module wfw_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wfw_pkg::t_q_head  i_head,
    output logic              o_pop,
    output logic              o_clearing,
    output logic              o_valid,
    output wfw_pkg::t_result  o_result
);

    logic [15:0]          r_mem [wfw_pkg::STORE_SIZE];
    logic [15:0]          r_rd_data;

    wfw_pkg::t_bk_state   r_state, n_state;
    wfw_pkg::t_addr       r_sweep, n_sweep;
    logic [9:0]           r_win_top, n_win_top;
    wfw_pkg::t_addr       r_win_base, n_win_base;
    logic [10:0]          r_win_width, n_win_width;
    wfw_pkg::t_cnt        r_win_pixels, n_win_pixels;
    wfw_pkg::t_cnt        r_cursor, n_cursor;
    logic [9:0]           r_col, n_col;
    logic [9:0]           r_row_y, n_row_y;
    wfw_pkg::t_addr       r_row_base, n_row_base;
    wfw_pkg::t_dirty      r_dirty, n_dirty;

    logic [16:0]          r_left, n_left;
    logic [15:0]          r_pixel, n_pixel;
    wfw_pkg::t_addr       r_f_addr, n_f_addr;
    wfw_pkg::t_addr       r_f_row_addr, n_f_row_addr;
    logic [10:0]          r_f_w, n_f_w;
    logic [10:0]          r_f_col, n_f_col;
    logic [10:0]          r_f_rows, n_f_rows;

    logic                 r_out_valid;
    wfw_pkg::t_result     r_out;

    logic                 mem_we;
    wfw_pkg::t_addr       mem_waddr;
    logic [15:0]          mem_wdata;
    logic                 finish;
    logic [15:0]          fin_rd;

    function automatic wfw_pkg::t_dirty widen(input wfw_pkg::t_dirty d,
                                              input logic [9:0] a,
                                              input logic [9:0] b);
        wfw_pkg::t_dirty w;
        w = d;
        if (!d.flag) begin
            w.flag = 1'b1;
            w.lo   = a;
            w.hi   = b;
        end else begin
            if (a < d.lo) begin
                w.lo = a;
            end
            if (b > d.hi) begin
                w.hi = b;
            end
        end
        return w;
    endfunction

    assign o_clearing = (r_state == wfw_pkg::BK_SWEEP);
    assign o_valid    = r_out_valid;
    assign o_result   = r_out;

    always_comb begin
        n_state      = r_state;
        n_sweep      = r_sweep;
        n_win_top    = r_win_top;
        n_win_base   = r_win_base;
        n_win_width  = r_win_width;
        n_win_pixels = r_win_pixels;
        n_cursor     = r_cursor;
        n_col        = r_col;
        n_row_y      = r_row_y;
        n_row_base   = r_row_base;
        n_dirty      = r_dirty;
        n_left       = r_left;
        n_pixel      = r_pixel;
        n_f_addr     = r_f_addr;
        n_f_row_addr = r_f_row_addr;
        n_f_w        = r_f_w;
        n_f_col      = r_f_col;
        n_f_rows     = r_f_rows;
        mem_we       = 1'b0;
        mem_waddr    = r_sweep;
        mem_wdata    = r_pixel;
        o_pop        = 1'b0;
        finish       = 1'b0;
        fin_rd       = '0;

        unique case (r_state)
            wfw_pkg::BK_SWEEP: begin
                mem_we    = 1'b1;
                mem_waddr = r_sweep;
                mem_wdata = '0;
                if (r_sweep == wfw_pkg::t_addr'(wfw_pkg::STORE_SIZE - 1)) begin
                    n_state = wfw_pkg::BK_IDLE;
                end else begin
                    n_sweep = r_sweep + wfw_pkg::t_addr'(1);
                end
            end
            wfw_pkg::BK_IDLE: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    unique case (i_head.cmd.op)
                        wfw_pkg::OP_NOP: begin
                            finish = 1'b1;
                        end
                        wfw_pkg::OP_WINDOW: begin
                            n_win_top    = i_head.cmd.row;
                            n_win_base   = i_head.cmd.addr;
                            n_win_width  = i_head.cmd.width;
                            n_win_pixels = i_head.cmd.pixels;
                            n_cursor     = '0;
                            n_col        = '0;
                            n_row_y      = i_head.cmd.row;
                            n_row_base   = i_head.cmd.addr;
                            finish       = 1'b1;
                        end
                        wfw_pkg::OP_RUN: begin
                            n_pixel = i_head.cmd.pixel;
                            n_left  = i_head.cmd.count;
                            if (i_head.cmd.count == 17'd0) begin
                                finish = 1'b1;
                            end else begin
                                n_state = wfw_pkg::BK_RUN;
                            end
                        end
                        wfw_pkg::OP_FILL: begin
                            // The rows are known up front, so the range widens now.
                            n_dirty = widen(r_dirty, i_head.cmd.row,
                                            10'({1'b0, i_head.cmd.row}
                                                + i_head.cmd.height - 11'd1));
                            n_pixel      = i_head.cmd.pixel;
                            n_f_addr     = i_head.cmd.addr;
                            n_f_row_addr = i_head.cmd.addr;
                            n_f_w        = i_head.cmd.width;
                            n_f_col      = i_head.cmd.width;
                            n_f_rows     = i_head.cmd.height;
                            n_state      = wfw_pkg::BK_FILL;
                        end
                        wfw_pkg::OP_MARK: begin
                            n_dirty.flag = 1'b1;
                            n_dirty.lo   = '0;
                            n_dirty.hi   = 10'(wfw_pkg::PANEL_HEIGHT - 1);
                            finish       = 1'b1;
                        end
                        wfw_pkg::OP_UNMARK: begin
                            n_dirty = '0;
                            finish  = 1'b1;
                        end
                        wfw_pkg::OP_READ: begin
                            n_state = wfw_pkg::BK_READ;
                        end
                        wfw_pkg::OP_CLEAR: begin
                            n_win_top    = '0;
                            n_win_base   = '0;
                            n_win_width  = 11'(wfw_pkg::PANEL_WIDTH);
                            n_win_pixels = wfw_pkg::t_cnt'(wfw_pkg::STORE_SIZE);
                            n_cursor     = '0;
                            n_col        = '0;
                            n_row_y      = '0;
                            n_row_base   = '0;
                            n_dirty      = '0;
                            n_sweep      = '0;
                            n_state      = wfw_pkg::BK_SWEEP;
                            finish       = 1'b1;
                        end
                    endcase
                end
            end
            wfw_pkg::BK_RUN: begin
                mem_we    = 1'b1;
                mem_waddr = r_row_base + wfw_pkg::t_addr'(r_col);
                n_dirty   = widen(r_dirty, r_row_y, r_row_y);
                n_left    = r_left - 17'd1;
                // The cursor walks the window row by row and wraps after its last pixel.
                if (r_cursor + wfw_pkg::t_cnt'(1) >= r_win_pixels) begin
                    n_cursor   = '0;
                    n_col      = '0;
                    n_row_y    = r_win_top;
                    n_row_base = r_win_base;
                end else if ({1'b0, r_col} == r_win_width - 11'd1) begin
                    n_cursor   = r_cursor + wfw_pkg::t_cnt'(1);
                    n_col      = '0;
                    n_row_y    = r_row_y + 10'd1;
                    n_row_base = r_row_base + wfw_pkg::t_addr'(wfw_pkg::PANEL_WIDTH);
                end else begin
                    n_cursor = r_cursor + wfw_pkg::t_cnt'(1);
                    n_col    = r_col + 10'd1;
                end
                if (r_left == 17'd1) begin
                    finish  = 1'b1;
                    n_state = wfw_pkg::BK_IDLE;
                end
            end
            wfw_pkg::BK_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = r_f_addr;
                if (r_f_col == 11'd1) begin
                    if (r_f_rows == 11'd1) begin
                        finish  = 1'b1;
                        n_state = wfw_pkg::BK_IDLE;
                    end else begin
                        n_f_rows     = r_f_rows - 11'd1;
                        n_f_row_addr = r_f_row_addr
                                     + wfw_pkg::t_addr'(wfw_pkg::PANEL_WIDTH);
                        n_f_addr     = r_f_row_addr
                                     + wfw_pkg::t_addr'(wfw_pkg::PANEL_WIDTH);
                        n_f_col      = r_f_w;
                    end
                end else begin
                    n_f_addr = r_f_addr + wfw_pkg::t_addr'(1);
                    n_f_col  = r_f_col - 11'd1;
                end
            end
            wfw_pkg::BK_READ: begin
                fin_rd  = r_rd_data;
                finish  = 1'b1;
                n_state = wfw_pkg::BK_IDLE;
            end
            default: begin
                n_state = wfw_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= wfw_pkg::BK_SWEEP;
            r_sweep      <= '0;
            r_win_top    <= '0;
            r_win_base   <= '0;
            r_win_width  <= 11'(wfw_pkg::PANEL_WIDTH);
            r_win_pixels <= wfw_pkg::t_cnt'(wfw_pkg::STORE_SIZE);
            r_cursor     <= '0;
            r_col        <= '0;
            r_row_y      <= '0;
            r_row_base   <= '0;
            r_dirty      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_sweep      <= n_sweep;
            r_win_top    <= n_win_top;
            r_win_base   <= n_win_base;
            r_win_width  <= n_win_width;
            r_win_pixels <= n_win_pixels;
            r_cursor     <= n_cursor;
            r_col        <= n_col;
            r_row_y      <= n_row_y;
            r_row_base   <= n_row_base;
            r_dirty      <= n_dirty;
            r_out_valid  <= finish;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left       <= n_left;
        r_pixel      <= n_pixel;
        r_f_addr     <= n_f_addr;
        r_f_row_addr <= n_f_row_addr;
        r_f_w        <= n_f_w;
        r_f_col      <= n_f_col;
        r_f_rows     <= n_f_rows;
        if (finish) begin
            r_out.dirty_valid <= n_dirty.flag;
            r_out.dirty_first <= n_dirty.flag ? n_dirty.lo : 10'd0;
            r_out.dirty_last  <= n_dirty.flag ? n_dirty.hi : 10'd0;
            r_out.cursor_pos  <= 17'(n_cursor);
            r_out.read_data   <= fin_rd;
        end
    end

    // Frame store: one write port and one registered read port at the queue head address.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[i_head.cmd.addr];
    end

`ifndef SYNTHESIS
    a_cursor_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor < r_win_pixels)
        else $error("cursor outside the window");

    a_col_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_col} < r_win_width)
        else $error("cursor column outside the window");

    a_dirty_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dirty.flag |-> (r_dirty.lo <= r_dirty.hi))
        else $error("dirty range inverted");

    a_pop_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_out_valid || (r_state != wfw_pkg::BK_IDLE)))
        else $error("command dropped without result");

    a_no_pop_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_clearing |-> !o_pop)
        else $error("command taken during store clearing");
`endif

endmodule
